// ===== hdl/bkvt_pkg.sv =====
package bkvt_pkg;

   // table geometry
   localparam int MAX_BUCKETS = 64;
   localparam int WAYS        = 4;
   localparam int KEY_BITS    = 64;
   localparam int VALUE_BITS  = 32;

   // port widths fixed by the interface
   localparam int KEY_PORT_W = 64;
   localparam int VAL_PORT_W = 32;
   localparam int CFG_W      = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CFG_W-1:0] DEFAULT_BUCKETS = CFG_W'(19);

   // register map, indexed by word address
   localparam logic REG_BUCKET_COUNT = 1'b0;

   // derived widths
   localparam int BKT_W   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int D_W     = $clog2(MAX_BUCKETS + 1);
   localparam int FILL_W  = $clog2(WAYS + 1);
   localparam int ENTRIES = MAX_BUCKETS * WAYS;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int VAL_W   = (VALUE_BITS < VAL_PORT_W) ? VALUE_BITS : VAL_PORT_W;

   // remainder unit: quotient digits per cycle and number of cycles
   localparam int DIV_STEP  = 4;
   localparam int DIV_ITERS = (KEY_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int KEY_PAD   = DIV_ITERS * DIV_STEP;
   localparam int CNT_W     = $clog2(DIV_ITERS + 1);

   typedef enum logic [1:0] {
      REQ_FIND,
      REQ_INSERT,
      REQ_GET,
      REQ_ERASE
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_FILL_CAP,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_ACT,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic load_req;
      logic fill_rd;
      logic fill_cap;
      logic key_rd;
      logic match_cap;
      logic way_inc;
      logic append;
      logic shift_rd;
      logic shift_wr;
      logic fill_dec;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         div_done;
      logic         way_lt_fill;
      logic         next_lt_fill;
      logic         key_match;
      logic         found;
      logic         rsp_free;
   } dp_status_type;

endpackage

// ===== hdl/bkvt_ram.sv =====
module bkvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bkvt_div.sv =====
module bkvt_div import bkvt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KEY_BITS-1:0] dividend,
   input  logic [D_W-1:0]      divisor,
   output logic                busy,
   output logic [BKT_W-1:0]    remainder
);

   logic [KEY_PAD-1:0] dvd_ff, dvd_in;
   logic [D_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic [D_W-1:0]     rem_step;

   // restoring remainder, DIV_STEP dividend bits per cycle, most significant first
   always_comb begin
      logic [D_W:0] trial;
      rem_step = rem_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {rem_step, dvd_ff[KEY_PAD-1-i]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_step = trial[D_W-1:0];
      end
   end

   // load on start, then advance until the count runs out
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         dvd_in  = KEY_PAD'(dividend);
         rem_in  = '0;
         cnt_in  = CNT_W'(DIV_ITERS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in  = dvd_ff << DIV_STEP;
         rem_in  = rem_step;
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff[BKT_W-1:0];

endmodule

// ===== hdl/bkvt_dp.sv =====
module bkvt_dp import bkvt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CFG_W-1:0]      cfg_bucket_count,
   input  logic [1:0]            req_type,
   input  logic [KEY_PORT_W-1:0] req_lookup_key,
   input  logic [VAL_PORT_W-1:0] req_entry_value,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [VAL_PORT_W-1:0] rsp_result_value,
   output logic                  rsp_created,
   output logic                  rsp_bucket_full
);

   req_kind_type        kind_ff, kind_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [VAL_W-1:0]    val_ff, val_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   way_ff, way_in;
   logic                found_ff, found_in;
   logic                created_ff, created_in;
   logic                full_ff, full_in;
   logic [VAL_W-1:0]    rv_ff, rv_in;
   logic [MAX_BUCKETS-1:0] valid_ff, valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [VAL_W-1:0]    rsp_rv_ff, rsp_rv_in;
   logic                rsp_created_ff, rsp_created_in;
   logic                rsp_full_ff, rsp_full_in;

   logic [D_W-1:0]      divisor;
   logic                div_busy;
   logic [BKT_W-1:0]    bucket;
   logic [ADDR_W-1:0]   base;
   logic                fill_lt_ways;
   logic [VAL_W-1:0]    append_val;
   logic [FILL_W:0]     next_way;

   logic                ent_wr_en, ent_rd_en;
   logic [ADDR_W-1:0]   ent_wr_addr, ent_rd_addr;
   logic [KEY_BITS-1:0] key_wr_data, key_rd_data;
   logic [VAL_W-1:0]    val_wr_data, val_rd_data;
   logic                fill_wr_en;
   logic [FILL_W-1:0]   fill_wr_data, fill_rd_data;

   // bucket count zero acts as one, above the table size as the table size
   always_comb begin
      if (cfg_bucket_count == '0) begin
         divisor = D_W'(1);
      end else if (int'(cfg_bucket_count) > MAX_BUCKETS) begin
         divisor = D_W'(MAX_BUCKETS);
      end else begin
         divisor = D_W'(cfg_bucket_count);
      end
   end

   bkvt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load_req),
      .dividend  (req_lookup_key[KEY_BITS-1:0]),
      .divisor   (divisor),
      .busy      (div_busy),
      .remainder (bucket)
   );

   // entry addressing within the selected bucket
   assign base         = ADDR_W'(ADDR_W'(bucket) * ADDR_W'(WAYS));
   assign fill_lt_ways = (int'(fill_ff) < WAYS);
   assign append_val   = (kind_ff == REQ_GET) ? '0 : val_ff;
   assign next_way     = {1'b0, way_ff} + (FILL_W+1)'(1);

   assign ent_rd_en   = cmd.key_rd | cmd.shift_rd;
   assign ent_rd_addr = cmd.shift_rd ? ADDR_W'(base + ADDR_W'(next_way))
                                     : ADDR_W'(base + ADDR_W'(way_ff));
   assign ent_wr_en   = (cmd.append & fill_lt_ways) | cmd.shift_wr;
   assign ent_wr_addr = cmd.append ? ADDR_W'(base + ADDR_W'(fill_ff))
                                   : ADDR_W'(base + ADDR_W'(way_ff));
   assign key_wr_data = cmd.append ? key_ff : key_rd_data;
   assign val_wr_data = cmd.append ? append_val : val_rd_data;

   assign fill_wr_en   = (cmd.append & fill_lt_ways) | cmd.fill_dec;
   assign fill_wr_data = cmd.append ? FILL_W'(fill_ff + FILL_W'(1))
                                    : FILL_W'(fill_ff - FILL_W'(1));

   bkvt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (key_rd_data)
   );

   bkvt_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (val_rd_data)
   );

   bkvt_ram #(.WIDTH(FILL_W), .DEPTH(MAX_BUCKETS)) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (bucket),
      .wr_data (fill_wr_data),
      .rd_en   (cmd.fill_rd),
      .rd_addr (bucket),
      .rd_data (fill_rd_data)
   );

   // request, scan and response registers
   always_comb begin
      kind_in        = kind_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      fill_in        = fill_ff;
      way_in         = way_ff;
      found_in       = found_ff;
      created_in     = created_ff;
      full_in        = full_ff;
      rv_in          = rv_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_rv_in      = rsp_rv_ff;
      rsp_created_in = rsp_created_ff;
      rsp_full_in    = rsp_full_ff;

      if (cmd.load_req) begin
         kind_in = req_kind_type'(req_type);
         key_in  = req_lookup_key[KEY_BITS-1:0];
         val_in  = req_entry_value[VAL_W-1:0];
      end

      // a bucket never written reads as empty
      if (cmd.fill_cap) begin
         fill_in    = valid_ff[bucket] ? fill_rd_data : '0;
         way_in     = '0;
         found_in   = 1'b0;
         created_in = 1'b0;
         full_in    = 1'b0;
         rv_in      = '0;
      end

      if (cmd.match_cap) begin
         found_in = 1'b1;
         rv_in    = val_rd_data;
      end

      if (cmd.way_inc) begin
         way_in = FILL_W'(next_way);
      end

      if (cmd.append) begin
         if (fill_lt_ways) begin
            created_in = 1'b1;
            rv_in      = append_val;
         end else begin
            full_in = 1'b1;
         end
      end

      if (fill_wr_en) begin
         valid_in[bucket] = 1'b1;
      end

      // hold the result word until taken
      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_found_in   = found_ff;
         rsp_rv_in      = rv_ff;
         rsp_created_in = created_ff;
         rsp_full_in    = full_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      fill_ff        <= fill_in;
      way_ff         <= way_in;
      found_ff       <= found_in;
      created_ff     <= created_in;
      full_ff        <= full_in;
      rv_ff          <= rv_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_rv_ff      <= rsp_rv_in;
      rsp_created_ff <= rsp_created_in;
      rsp_full_ff    <= rsp_full_in;
   end

   // status towards the controller
   assign status.kind         = kind_ff;
   assign status.div_done     = ~div_busy;
   assign status.way_lt_fill  = (way_ff < fill_ff);
   assign status.next_lt_fill = (next_way < {1'b0, fill_ff});
   assign status.key_match    = (key_rd_data == key_ff);
   assign status.found        = found_ff;
   assign status.rsp_free     = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_result_value = VAL_PORT_W'(rsp_rv_ff);
   assign rsp_created      = rsp_created_ff;
   assign rsp_bucket_full  = rsp_full_ff;

endmodule

// ===== hdl/bkvt_ctrl.sv =====
module bkvt_ctrl import bkvt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequence one request: remainder, fill read, scan, update, result
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.fill_rd = 1'b1;
               state_in    = ST_FILL_CAP;
            end
         end
         ST_FILL_CAP: begin
            cmd.fill_cap = 1'b1;
            state_in     = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (status.way_lt_fill) begin
               cmd.key_rd = 1'b1;
               state_in   = ST_SCAN_CMP;
            end else begin
               state_in = ST_ACT;
            end
         end
         ST_SCAN_CMP: begin
            if (status.key_match) begin
               cmd.match_cap = 1'b1;
               state_in      = ST_ACT;
            end else begin
               cmd.way_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_ACT: begin
            case (status.kind)
               REQ_INSERT: begin
                  cmd.append = 1'b1;
                  state_in   = ST_RESP;
               end
               REQ_GET: begin
                  cmd.append = ~status.found;
                  state_in   = ST_RESP;
               end
               REQ_ERASE: begin
                  state_in = status.found ? ST_SHIFT_RD : ST_RESP;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_SHIFT_RD: begin
            if (status.next_lt_fill) begin
               cmd.shift_rd = 1'b1;
               state_in     = ST_SHIFT_WR;
            end else begin
               cmd.fill_dec = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.way_inc  = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/bucketed_key_value_table_unit.sv =====
// From request word to result word: the remainder (4 key bits a cycle), the fill read,
// the fill capture, a key read and a compare per way scanned, the update, on an erase
// hit a read and a write per entry moved, and the output load once the result register
// is free. Requests go one at a time; the next word is taken the cycle after the
// result is loaded.
// Reset empties every bucket, idles the controller and output register, sets bucket_count 19.
module bucketed_key_value_table_unit import bkvt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic [KEY_PORT_W-1:0] req_lookup_key,
   input  logic [VAL_PORT_W-1:0] req_entry_value,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [VAL_PORT_W-1:0] rsp_result_value,
   output logic                  rsp_created,
   output logic                  rsp_bucket_full,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CFG_W-1:0] bucket_count_ff, bucket_count_in;
   logic             csr_wr;
   dp_cmd_type       cmd;
   dp_status_type    status;

   // register write on the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[2] == REG_BUCKET_COUNT);

   assign bucket_count_in = csr_wr ? csr_pwdata[CFG_W-1:0] : bucket_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= DEFAULT_BUCKETS;
      end else begin
         bucket_count_ff <= bucket_count_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_BUCKET_COUNT) ? CSR_DATA_W'(bucket_count_ff)
                                                          : '0;

   bkvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bkvt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg_bucket_count (bucket_count_ff),
      .req_type         (req_type),
      .req_lookup_key   (req_lookup_key),
      .req_entry_value  (req_entry_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_result_value (rsp_result_value),
      .rsp_created      (rsp_created),
      .rsp_bucket_full  (rsp_bucket_full)
   );

endmodule

// ===== dv/bkvt_tb_pkg.sv =====
package bkvt_tb_pkg;
   import bkvt_pkg::*;

   // one result word as the table should answer it
   typedef struct {
      logic                  found;
      logic [VAL_PORT_W-1:0] value;
      logic                  created;
      logic                  full;
   } table_answer_type;

   class table_scoreboard_type;
      logic [CFG_W-1:0]    bucket_count;
      logic [FILL_W-1:0]   fill [MAX_BUCKETS];
      logic [KEY_BITS-1:0] keys [ENTRIES];
      logic [VAL_W-1:0]    vals [ENTRIES];
      table_answer_type    answers [$];
      int                  errors;

      function new();
         bucket_count = DEFAULT_BUCKETS;
         foreach (fill[i]) fill[i] = '0;
         errors = 0;
      endfunction

      // zero acts as one bucket, anything past the table size as the full table
      function int unsigned buckets_in_use();
         if (bucket_count == 0) return 1;
         if (bucket_count > MAX_BUCKETS) return MAX_BUCKETS;
         return bucket_count;
      endfunction

      // work out the answer to an accepted request and update the shadow table
      function void note_request(req_kind_type kind, logic [KEY_PORT_W-1:0] key_in,
                                 logic [VAL_PORT_W-1:0] value_in);
         logic [KEY_BITS-1:0] key;
         logic [VAL_W-1:0]    value;
         int unsigned         bkt, base, used, hit, w;
         table_answer_type    ans;
         key   = key_in[KEY_BITS-1:0];
         value = value_in[VAL_W-1:0];
         bkt   = int'(64'(key) % 64'(buckets_in_use()));
         base  = bkt * WAYS;
         used  = fill[bkt];
         if (used > WAYS) used = WAYS;
         ans = '{1'b0, '0, 1'b0, 1'b0};

         // scan from the oldest entry, stop on the first match
         hit = used;
         for (w = 0; w < used; w++) begin
            if (keys[base + w] == key) begin
               hit = w;
               break;
            end
         end
         if (hit < used) begin
            ans.found = 1'b1;
            ans.value = VAL_PORT_W'(vals[base + hit]);
         end

         case (kind)
            REQ_INSERT, REQ_GET: begin
               if (!(kind == REQ_GET && ans.found)) begin
                  if (kind == REQ_GET) value = '0;
                  if (used < WAYS) begin
                     keys[base + used] = key;
                     vals[base + used] = value;
                     fill[bkt]         = FILL_W'(used + 1);
                     ans.created       = 1'b1;
                     ans.value         = VAL_PORT_W'(value);
                  end else begin
                     ans.full = 1'b1;
                  end
               end
            end
            REQ_ERASE: begin
               // close the gap left by the removed entry
               if (ans.found) begin
                  for (w = hit; w + 1 < used; w++) begin
                     keys[base + w] = keys[base + w + 1];
                     vals[base + w] = vals[base + w + 1];
                  end
                  fill[bkt] = FILL_W'(used - 1);
               end
            end
            default: ;
         endcase
         answers.push_back(ans);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      // compare a result word with the oldest outstanding answer
      function void check_result(logic found, logic [VAL_PORT_W-1:0] value, logic created,
                                 logic full);
         table_answer_type want;
         if (answers.size() == 0) begin
            $display("%0t: result with nothing outstanding: found=%0b value=%0h",
                     $time, found, value);
            $display("%0t: created=%0b full=%0b", $time, created, full);
            errors++;
            return;
         end
         want = answers.pop_front();
         compare_field("found", 64'(want.found), 64'(found));
         compare_field("result_value", 64'(want.value), 64'(value));
         compare_field("created", 64'(want.created), 64'(created));
         compare_field("bucket_full", 64'(want.full), 64'(full));
      endfunction
   endclass

endpackage

// ===== dv/tb_bucketed_key_value_table_unit.sv =====
module tb_bucketed_key_value_table_unit;
   import bkvt_pkg::*;
   import bkvt_tb_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int ITEMS_PER_PHASE = 305;
   localparam int POOL_SIZE       = 16;
   localparam logic [CSR_ADDR_W-1:0] BUCKET_COUNT_ADDR =
      CSR_ADDR_W'(4 * int'(REG_BUCKET_COUNT));

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_type;
   logic [KEY_PORT_W-1:0] req_lookup_key;
   logic [VAL_PORT_W-1:0] req_entry_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_found;
   logic [VAL_PORT_W-1:0] rsp_result_value;
   logic                  rsp_created;
   logic                  rsp_bucket_full;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    req_idle_pct;
   int                    rsp_idle_pct;
   int                    stall_cycles;
   logic [KEY_PORT_W-1:0] key_pool [POOL_SIZE];
   table_scoreboard_type  sb;

   bucketed_key_value_table_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_lookup_key   (req_lookup_key),
      .req_entry_value  (req_entry_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_result_value (rsp_result_value),
      .rsp_created      (rsp_created),
      .rsp_bucket_full  (rsp_bucket_full),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stall the result side at random
   always @(negedge clock) begin
      rsp_ready <= (rsp_idle_pct == 0) || ($urandom_range(99) >= rsp_idle_pct);
   end

   // check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_found, rsp_result_value, rsp_created, rsp_bucket_full);
   end

   // abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // present one request word, hold it until taken; starts and ends at a falling edge
   task automatic send_item(req_kind_type kind, logic [KEY_PORT_W-1:0] key,
                            logic [VAL_PORT_W-1:0] value);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_lookup_key  <= key;
      req_entry_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, key, value);
      @(negedge clock);
   endtask

   // write the bucket count, then read it back
   task automatic set_bucket_count(logic [CFG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= BUCKET_COUNT_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.bucket_count = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.compare_field("bucket_count readback", 64'(value), 64'(csr_prdata));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // wait for every outstanding answer, then let the block settle
   task automatic drain();
      while (sb.answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // random traffic, mostly on a small key pool so buckets fill, hit and overflow
   task automatic run_random(int count);
      int unsigned           n, pick;
      logic [KEY_PORT_W-1:0] key;
      req_kind_type          kind;
      n = sb.buckets_in_use();
      foreach (key_pool[i]) begin
         if (i % 4 == 0)
            key_pool[i] = {$urandom, $urandom};
         else
            key_pool[i] = 64'($urandom_range(3)) + 64'(n) * 64'($urandom);
      end
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 80)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
         else if (pick < 90)
            key = {$urandom, $urandom};
         else
            key = 64'($urandom_range(255));
         kind = req_kind_type'($urandom_range(3));
         send_item(kind, key, $urandom);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      int bucket_plan [5];
      bucket_plan     = '{19, 1, 64, 0, 127};
      sb              = new();
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = REQ_FIND;
      req_lookup_key  = '0;
      req_entry_value = '0;
      rsp_ready       = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      req_idle_pct    = 38;
      rsp_idle_pct    = 50;
      stall_cycles    = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: keys 0, 19, 38, 57 all land in bucket 0 at the reset count
      send_item(REQ_FIND,   64'd0,  32'd0);         // miss on an empty table
      send_item(REQ_ERASE,  64'd0,  32'd0);         // erase miss
      send_item(REQ_GET,    64'd0,  32'hDEAD_BEEF); // create with zero
      send_item(REQ_INSERT, 64'd0,  32'hFFFF_FFFF); // duplicate key
      send_item(REQ_FIND,   64'd0,  32'd0);         // oldest duplicate wins
      send_item(REQ_INSERT, 64'd19, 32'h1234_5678);
      send_item(REQ_INSERT, 64'd38, 32'hA5A5_A5A5); // bucket now full
      send_item(REQ_INSERT, 64'd57, 32'h0000_0001); // refused, no match
      send_item(REQ_INSERT, 64'd0,  32'h0000_0001); // refused, match reported
      send_item(REQ_GET,    64'd57, 32'd0);         // refused get
      send_item(REQ_GET,    64'd38, 32'd0);         // get hit
      send_item(REQ_ERASE,  64'd0,  32'd0);         // erase oldest, shift the rest
      send_item(REQ_FIND,   64'd0,  32'd0);         // now the duplicate
      send_item(REQ_ERASE,  64'd19, 32'd0);         // erase from the middle
      send_item(REQ_ERASE,  64'd38, 32'd0);         // erase the last way
      send_item(REQ_ERASE,  64'd0,  32'd0);
      send_item(REQ_FIND,   '1,     32'd0);
      send_item(REQ_INSERT, '1,     32'hFFFF_FFFF);
      send_item(REQ_GET,    '1,     32'd0);
      send_item(REQ_ERASE,  '1,     32'd0);
      send_item(REQ_GET,    64'h8000_0000_0000_0000, 32'h5555_5555);
      send_item(REQ_ERASE,  64'h8000_0000_0000_0000, 32'd0);
      req_valid <= 1'b0;
      drain();

      // random phases; the table keeps its contents across count changes
      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               req_idle_pct = 38;
               rsp_idle_pct = 50;
            end
            1: begin
               req_idle_pct = 50;
               rsp_idle_pct = 38;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         if (phase < 5)
            set_bucket_count(CFG_W'(bucket_plan[phase]));
         else
            set_bucket_count(CFG_W'($urandom_range(63, 2)));
         run_random(ITEMS_PER_PHASE);
         drain();
      end

      if (sb.errors == 0 && sb.answers.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/bkvt_pkg.sv
hdl/bkvt_ram.sv
hdl/bkvt_div.sv
hdl/bkvt_dp.sv
hdl/bkvt_ctrl.sv
hdl/bucketed_key_value_table_unit.sv
dv/bkvt_tb_pkg.sv
dv/tb_bucketed_key_value_table_unit.sv
